// File: design/software_timer_slot_table_core_macros.svh
// Assertion helpers shared by the timer slot table design.
`ifndef SOFTWARE_TIMER_SLOT_TABLE_CORE_MACROS_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SWT_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/swt_pkg.sv
package swt_pkg;

    localparam int SLOTS       = 8;
    localparam int ID_BITS     = 8;
    localparam int TAG_BITS    = 16;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 32;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_CHECK = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_EXPIRY = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic shift;
        logic stop;
    } t_cell_ctl;

    typedef struct packed {
        t_kind       kind;
        logic        start_ok;
        logic [2:0]  slot;
        logic [7:0]  expired_id;
        logic [15:0] expired_tag;
        logic        any_active;
        logic        last;
    } t_result;

endpackage

// File: design/software_timer_slot_table_core.sv
// Tick and stop: no result; the next beat is taken in the following cycle.
// Start: its status beat goes to the output register, or to the hold one while output stalls.
// Check: accept in idle, a scan state rotating the slot row once past the head cell, and one
//   flush state; a hit stalls the scan while hold and output are both full; each expiry
//   beat waits in a hold register until the next hit, the final beat leaves after the flush.
// Synchronous active-low reset clears all slots, the tick count and the handshake state.
`include "software_timer_slot_table_core_macros.svh"

module software_timer_slot_table_core #(
    parameter int SLOTS    = swt_pkg::SLOTS,
    parameter int ID_BITS  = swt_pkg::ID_BITS,
    parameter int TAG_BITS = swt_pkg::TAG_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // timer_id[7:0], duration[23:8], handler_tag[39:24]
    input  logic [1:0]  i_s_tuser,   // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // start_ok[0], slot[3:1], expired_id[11:4],
                                     // expired_tag[27:12], any_active[28], zero[31:29]
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NRES_W = $clog2(swt_pkg::MAX_RESULTS + 1);
    localparam int CNT_W  = swt_pkg::CNT_W;

    swt_pkg::t_state    r_state;
    swt_pkg::t_state    n_state;
    logic [IDX_W-1:0]   r_step;
    logic [IDX_W-1:0]   n_step;
    logic [NRES_W-1:0]  r_nres;
    logic [NRES_W-1:0]  n_nres;
    logic [CNT_W-1:0]   r_tick;
    logic [CNT_W-1:0]   n_tick;
    logic               r_out_v;
    logic               n_out_v;
    logic               r_hold_v;
    logic               n_hold_v;
    swt_pkg::t_result   r_out;
    swt_pkg::t_result   n_out;
    swt_pkg::t_result   r_hold;
    swt_pkg::t_result   n_hold;

    swt_pkg::t_mode     w_mode;
    logic [ID_BITS-1:0] w_id;
    logic [15:0]        w_dur;
    logic [TAG_BITS-1:0] w_tag_in;
    logic [CNT_W-1:0]   w_deadline;
    logic               w_acc;
    logic               w_out_free;
    logic               w_hit;
    logic               w_step_go;
    logic               w_kill;
    swt_pkg::t_cell_ctl w_ctl;

    logic [SLOTS-1:0]   w_valid;
    logic [SLOTS-1:0]   w_match;
    logic [SLOTS-1:0]   w_expired;
    logic [SLOTS-1:0]   w_load;
    logic [ID_BITS-1:0] w_owner [SLOTS];
    logic [CNT_W-1:0]   w_dl [SLOTS];
    logic [TAG_BITS-1:0] w_tag [SLOTS];

    logic               w_match_any;
    logic               w_free_any;
    logic [IDX_W-1:0]   w_match_idx;
    logic [IDX_W-1:0]   w_free_idx;
    logic [IDX_W-1:0]   w_sel;
    logic               w_ok;
    logic               w_any_after;

    swt_pkg::t_result   w_start_res;
    swt_pkg::t_result   w_exp_res;
    swt_pkg::t_result   w_none_res;

    assign w_mode     = swt_pkg::t_mode'(i_s_tuser);
    assign w_id       = ID_BITS'(i_s_tdata[7:0]);
    assign w_dur      = i_s_tdata[23:8];
    assign w_tag_in   = TAG_BITS'(i_s_tdata[39:24]);
    assign w_deadline = r_tick + CNT_W'(w_dur);

    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_v || i_m_tready;
    assign w_hit      = w_expired[0] && (r_nres < NRES_W'(swt_pkg::MAX_RESULTS));
    assign w_step_go  = !w_hit || !r_hold_v || w_out_free;
    assign w_kill     = w_hit;
    assign w_any_after = |(w_valid & ~SLOTS'(w_hit));

    // slot row: cell i takes from cell i+1, the head wraps to the tail
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        localparam int NXT = (g + 1) % SLOTS;
        logic w_nxt_valid;

        if (g == SLOTS - 1) begin : g_tail
            assign w_nxt_valid = w_valid[NXT] && !w_kill;
        end else begin : g_body
            assign w_nxt_valid = w_valid[NXT];
        end

        assign w_load[g] = (r_state == swt_pkg::ST_IDLE) && w_acc &&
                           (w_mode == swt_pkg::MODE_START) && w_ok &&
                           (w_sel == IDX_W'(g));

        swt_cell #(
            .ID_BITS  (ID_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_load         (w_load[g]),
            .i_id           (w_id),
            .i_deadline     (w_deadline),
            .i_tag          (w_tag_in),
            .i_now          (r_tick),
            .i_nxt_valid    (w_nxt_valid),
            .i_nxt_owner    (w_owner[NXT]),
            .i_nxt_deadline (w_dl[NXT]),
            .i_nxt_tag      (w_tag[NXT]),
            .o_valid        (w_valid[g]),
            .o_owner        (w_owner[g]),
            .o_deadline     (w_dl[g]),
            .o_tag          (w_tag[g]),
            .o_match        (w_match[g]),
            .o_expired      (w_expired[g])
        );
    end

    always_comb begin
        w_match_any = 1'b0;
        w_free_any  = 1'b0;
        w_match_idx = '0;
        w_free_idx  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!w_match_any && w_match[i]) begin
                w_match_any = 1'b1;
                w_match_idx = IDX_W'(i);
            end
            if (!w_free_any && !w_valid[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign w_sel = w_match_any ? w_match_idx : w_free_idx;
    assign w_ok  = w_match_any || w_free_any;

    always_comb begin
        w_start_res             = '0;
        w_start_res.kind        = swt_pkg::KIND_START;
        w_start_res.start_ok    = w_ok;
        w_start_res.slot        = w_ok ? 3'(w_sel) : 3'd0;
        w_start_res.any_active  = w_ok || (|w_valid);
        w_start_res.last        = 1'b1;

        w_exp_res               = '0;
        w_exp_res.kind          = swt_pkg::KIND_EXPIRY;
        w_exp_res.slot          = 3'(r_step);
        w_exp_res.expired_id    = 8'(w_owner[0]);
        w_exp_res.expired_tag   = 16'(w_tag[0]);
        w_exp_res.any_active    = w_any_after;

        w_none_res              = '0;
        w_none_res.kind         = swt_pkg::KIND_NONE;
        w_none_res.any_active   = |w_valid;
        w_none_res.last         = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swt_pkg::ST_IDLE: begin
                if (w_acc && (w_mode == swt_pkg::MODE_CHECK)) begin
                    n_state = swt_pkg::ST_SCAN;
                end
            end
            swt_pkg::ST_SCAN: begin
                if (w_step_go && (r_step == IDX_W'(SLOTS - 1))) begin
                    n_state = swt_pkg::ST_FLUSH;
                end
            end
            swt_pkg::ST_FLUSH: begin
                if (w_out_free) begin
                    n_state = swt_pkg::ST_IDLE;
                end
            end
            default: n_state = swt_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready  = 1'b0;
        w_ctl.shift = 1'b0;
        w_ctl.stop  = 1'b0;
        case (r_state)
            swt_pkg::ST_IDLE: begin
                o_s_tready = !r_hold_v;
                w_ctl.stop = i_s_tvalid && !r_hold_v && (w_mode == swt_pkg::MODE_STOP);
            end
            swt_pkg::ST_SCAN: begin
                w_ctl.shift = w_step_go;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // result staging, counters
    always_comb begin
        n_out_v  = r_out_v && !i_m_tready;
        n_out    = r_out;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_step   = r_step;
        n_nres   = r_nres;
        n_tick   = r_tick;
        case (r_state)
            swt_pkg::ST_IDLE: begin
                if (r_hold_v && w_out_free) begin
                    n_out    = r_hold;
                    n_out_v  = 1'b1;
                    n_hold_v = 1'b0;
                end else if (w_acc) begin
                    case (w_mode)
                        swt_pkg::MODE_TICK: begin
                            n_tick = r_tick + CNT_W'(1);
                        end
                        swt_pkg::MODE_START: begin
                            if (w_out_free) begin
                                n_out   = w_start_res;
                                n_out_v = 1'b1;
                            end else begin
                                n_hold   = w_start_res;
                                n_hold_v = 1'b1;
                            end
                        end
                        swt_pkg::MODE_CHECK: begin
                            n_step = '0;
                            n_nres = '0;
                        end
                        default: begin
                            n_tick = r_tick;
                        end
                    endcase
                end
            end
            swt_pkg::ST_SCAN: begin
                if (w_step_go) begin
                    n_step = r_step + IDX_W'(1);
                    if (w_hit) begin
                        if (r_hold_v) begin
                            n_out   = r_hold;
                            n_out_v = 1'b1;
                        end
                        n_hold   = w_exp_res;
                        n_hold_v = 1'b1;
                        n_nres   = r_nres + NRES_W'(1);
                    end
                end
            end
            swt_pkg::ST_FLUSH: begin
                if (w_out_free) begin
                    if (r_hold_v) begin
                        n_out      = r_hold;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = w_none_res;
                    end
                    n_out_v  = 1'b1;
                    n_hold_v = 1'b0;
                end
            end
            default: begin
                n_hold_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= swt_pkg::ST_IDLE;
            r_step   <= '0;
            r_nres   <= '0;
            r_tick   <= '0;
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_nres   <= n_nres;
            r_tick   <= n_tick;
            r_out_v  <= n_out_v;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {3'b000, r_out.any_active, r_out.expired_tag, r_out.expired_id,
                         r_out.slot, r_out.start_ok};

    `SWT_ASSERT_IMPLY(a_idle_hold_is_last,
        (r_state == swt_pkg::ST_IDLE) && r_hold_v, r_hold.last,
        "held beat in idle is not a final beat")
    `SWT_ASSERT_IMPLY(a_no_shift_off_scan,
        r_state != swt_pkg::ST_SCAN,
        !w_ctl.shift && (w_load == '0 || r_state == swt_pkg::ST_IDLE),
        "slot row moved outside a scan")
    `SWT_ASSERT_NEXT(a_scan_to_flush,
        (r_state == swt_pkg::ST_SCAN) && w_step_go && (r_step == IDX_W'(SLOTS - 1)),
        r_state == swt_pkg::ST_FLUSH, "scan did not end after one rotation")
    `SWT_ASSERT_IMPLY(a_result_cap,
        r_state == swt_pkg::ST_SCAN, r_nres <= NRES_W'(swt_pkg::MAX_RESULTS),
        "too many expiry beats in one check")

endmodule

// File: design/swt_cell.sv
module swt_cell #(
    parameter int ID_BITS  = swt_pkg::ID_BITS,
    parameter int TAG_BITS = swt_pkg::TAG_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  swt_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_load,
    input  logic [ID_BITS-1:0]         i_id,
    input  logic [swt_pkg::CNT_W-1:0]  i_deadline,
    input  logic [TAG_BITS-1:0]        i_tag,
    input  logic [swt_pkg::CNT_W-1:0]  i_now,
    input  logic                       i_nxt_valid,
    input  logic [ID_BITS-1:0]         i_nxt_owner,
    input  logic [swt_pkg::CNT_W-1:0]  i_nxt_deadline,
    input  logic [TAG_BITS-1:0]        i_nxt_tag,
    output logic                       o_valid,
    output logic [ID_BITS-1:0]         o_owner,
    output logic [swt_pkg::CNT_W-1:0]  o_deadline,
    output logic [TAG_BITS-1:0]        o_tag,
    output logic                       o_match,
    output logic                       o_expired
);

    logic                      r_valid;
    logic                      n_valid;
    logic [ID_BITS-1:0]        r_owner;
    logic [ID_BITS-1:0]        n_owner;
    logic [swt_pkg::CNT_W-1:0] r_deadline;
    logic [swt_pkg::CNT_W-1:0] n_deadline;
    logic [TAG_BITS-1:0]       r_tag;
    logic [TAG_BITS-1:0]       n_tag;

    assign o_valid    = r_valid;
    assign o_owner    = r_owner;
    assign o_deadline = r_deadline;
    assign o_tag      = r_tag;
    assign o_match    = r_valid && (r_owner == i_id);
    assign o_expired  = r_valid && (r_deadline < i_now);

    always_comb begin
        n_valid    = r_valid;
        n_owner    = r_owner;
        n_deadline = r_deadline;
        n_tag      = r_tag;
        if (i_load) begin
            n_valid    = 1'b1;
            n_owner    = i_id;
            n_deadline = i_deadline;
            n_tag      = i_tag;
        end else if (i_ctl.shift) begin
            n_valid    = i_nxt_valid;
            n_owner    = i_nxt_owner;
            n_deadline = i_nxt_deadline;
            n_tag      = i_nxt_tag;
        end else if (i_ctl.stop && o_match) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_owner    <= n_owner;
        r_deadline <= n_deadline;
        r_tag      <= n_tag;
    end

endmodule
